// ===== rtl/prct_pkg.sv =====
`default_nettype none

package prct_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int BEEP_W     = 8;
    localparam int OPTION_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS = 3'd0,
        REG_SLOT0      = 3'd1,
        REG_SLOT1      = 3'd2,
        REG_SLOT2      = 3'd3,
        REG_SLOT3      = 3'd4,
        REG_BEEP_HALF  = 3'd5
    } t_reg_idx;

    localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd60;
    localparam logic [BEEP_W-1:0] BEEP_HALF_RST  = 8'd10;

    function automatic logic [TICK_W-1:0] slot_reset_value(input int slot);
        logic [TICK_W-1:0] v;
        case (slot)
            0:       v = 16'd500;
            1:       v = 16'd1500;
            2:       v = 16'd3000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [TICK_W-1:0]                 long_press;
        logic [SLOT_COUNT-1:0][TICK_W-1:0] slot_dur;
        logic [BEEP_W-1:0]                 beep_half;
    } t_cfg;

    // Packed so that the last output field, led_on, sits in bit 0.
    typedef struct packed {
        logic                alert_raised;
        logic                countdown_running;
        logic [OPTION_W-1:0] option_index;
        t_event              press_event;
        logic                buzzer_on;
        logic                led_on;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/prct_tick.sv =====
`default_nettype none

module prct_tick (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  wire                  i_level,
    input  prct_pkg::t_cfg       i_cfg,
    output prct_pkg::t_result    o_result
);
    import prct_pkg::*;

    logic              r_prev_level, n_prev_level;
    logic              r_press_active, n_press_active;
    logic [TICK_W-1:0] r_held, n_held;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TICK_W-1:0] r_remaining, n_remaining;
    logic              r_armed, n_armed;
    logic              r_alert, n_alert;
    logic [BEEP_W-1:0] r_beep_cnt, n_beep_cnt;
    logic              r_beep_phase, n_beep_phase;

    logic [TICK_W-1:0] rem_dec;
    logic [TICK_W-1:0] next_dur;
    logic [SLOT_W-1:0] next_slot;
    logic [BEEP_W:0]   beep_inc;
    logic [BEEP_W-1:0] half;
    t_event            event_code;
    logic              led, buzz;

    assign rem_dec   = r_remaining - 1'b1;
    assign next_slot = (r_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_slot + 1'b1;
    assign next_dur  = i_cfg.slot_dur[next_slot];
    assign half      = (i_cfg.beep_half == '0) ? BEEP_W'(1) : i_cfg.beep_half;
    assign beep_inc  = {1'b0, r_beep_cnt} + 1'b1;

    always_comb begin
        n_remaining    = r_remaining;
        n_armed        = r_armed;
        n_alert        = r_alert;
        n_press_active = r_press_active;
        n_held         = r_held;
        n_slot         = r_slot;
        n_beep_cnt     = r_beep_cnt;
        n_beep_phase   = r_beep_phase;
        event_code     = EVT_NONE;
        led            = 1'b0;
        buzz           = 1'b0;

        // The countdown steps before the button is looked at.
        if (r_armed) begin
            n_remaining = rem_dec;
            if (rem_dec == '0) begin
                n_armed = 1'b0;
                n_alert = 1'b1;
            end
        end

        if (!r_press_active) begin
            if (r_prev_level && !i_level) begin
                n_press_active = 1'b1;
                n_held         = '0;
            end
        end else if (!i_level) begin
            if (r_held != '1) begin
                n_held = r_held + 1'b1;
            end
        end else begin
            event_code     = (r_held >= i_cfg.long_press) ? EVT_LONG : EVT_SHORT;
            n_press_active = 1'b0;
        end
        n_prev_level = i_level;

        case (event_code)
            EVT_SHORT: begin
                n_slot = next_slot;
                if (next_dur == '0) begin
                    n_armed     = 1'b0;
                    n_remaining = '0;
                    n_alert     = 1'b0;
                end else begin
                    n_armed     = 1'b1;
                    n_remaining = next_dur;
                end
            end
            EVT_LONG: begin
                n_armed     = 1'b0;
                n_remaining = '0;
                n_alert     = 1'b0;
            end
            default: begin
            end
        endcase

        if (n_alert) begin
            led  = 1'b1;
            buzz = !r_beep_phase;
            // Nine bits, so that a count left high by a smaller half period still wraps.
            if (beep_inc >= {1'b0, half}) begin
                n_beep_cnt   = '0;
                n_beep_phase = !r_beep_phase;
            end else begin
                n_beep_cnt = beep_inc[BEEP_W-1:0];
            end
        end else begin
            n_beep_cnt   = '0;
            n_beep_phase = 1'b0;
        end
    end

    always_comb begin
        o_result                   = '0;
        o_result.led_on            = led;
        o_result.buzzer_on         = buzz;
        o_result.press_event       = event_code;
        o_result.option_index      = OPTION_W'(n_slot);
        o_result.countdown_running = n_armed;
        o_result.alert_raised      = n_alert;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b1;
            r_press_active <= 1'b0;
            r_held         <= '0;
            r_slot         <= '0;
            r_remaining    <= '0;
            r_armed        <= 1'b0;
            r_alert        <= 1'b0;
            r_beep_cnt     <= '0;
            r_beep_phase   <= 1'b0;
        end else if (i_advance) begin
            r_prev_level   <= n_prev_level;
            r_press_active <= n_press_active;
            r_held         <= n_held;
            r_slot         <= n_slot;
            r_remaining    <= n_remaining;
            r_armed        <= n_armed;
            r_alert        <= n_alert;
            r_beep_cnt     <= n_beep_cnt;
            r_beep_phase   <= n_beep_phase;
        end
    end

`ifndef SYNTH
    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_remaining != '0))
        else $error("countdown armed with nothing left to count");

    a_release_ends_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (event_code != EVT_NONE)) |=> !r_press_active)
        else $error("press still active after a classed release");

    a_quiet_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_alert |-> ((r_beep_cnt == '0) && !r_beep_phase))
        else $error("beep pattern not at its start while no alert");
`endif

endmodule

`default_nettype wire

// ===== rtl/press_classified_reminder_timer_core.sv =====
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: button_level, zero fill to 8 bits
// m_axis    out        tdata: led_on, buzzer_on, press_event, option_index,
//                             countdown_running, alert_raised
// cfg       in         write enable, register index, 16-bit data
//
// One poll tick is taken per cycle while s_axis_tready is high; its result is
// registered. A two-entry output stage (result register plus skid register)
// lets a tick be accepted while a result still waits, and s_axis_tready falls
// only when both entries are full. Reset is synchronous and active low; it
// restores the register defaults and the released, idle timer state.

module press_classified_reminder_timer_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [7:0]                          s_axis_tdata,  // [0] button_level
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [0] led_on, [1] buzzer_on, [3:2] press_event, [5:4] option_index,
    // [6] countdown_running, [7] alert_raised
    output logic [7:0]                          m_axis_tdata,
    input  wire                                 i_cfg_we,
    input  wire  [prct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [prct_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import prct_pkg::*;

    t_cfg    r_cfg;
    t_result tick_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    accept, out_take;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press <= LONG_PRESS_RST;
            r_cfg.beep_half  <= BEEP_HALF_RST;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_cfg.slot_dur[s] <= slot_reset_value(s);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LONG_PRESS: r_cfg.long_press <= i_cfg_data[TICK_W-1:0];
                REG_BEEP_HALF:  r_cfg.beep_half  <= i_cfg_data[BEEP_W-1:0];
                REG_SLOT0, REG_SLOT1, REG_SLOT2, REG_SLOT3: begin
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (i_cfg_index == CFG_IDX_W'(int'(REG_SLOT0) + s)) begin
                            r_cfg.slot_dur[s] <= i_cfg_data[TICK_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    prct_tick u_tick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_level   (s_axis_tdata[0]),
        .i_cfg     (r_cfg),
        .o_result  (tick_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                    r_out       <= tick_result;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= tick_result;
                end
            end else if (out_take) begin
                // The skid entry moves up; the result stage empties if there is none.
                r_out_valid  <= r_skid_valid;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the result stage is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("request accepted behind a stalled result was not kept");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> !r_skid_valid)
        else $error("skid entry not drained after the result was taken");
`endif

endmodule

`default_nettype wire
